/* hw/rtl/mbrs_pkg.sv */
// Shared types, constants and helpers of the Modbus register server.
// Used by mbrs_ctrl, mbrs_dp and modbus_register_server_unit; depends on nothing.
package mbrs_pkg;

  localparam int STORE_DEPTH    = 4096;
  localparam int MAX_READ_BITS  = 2000;
  localparam int MAX_READ_REGS  = 125;
  localparam int MAX_WRITE_REGS = 123;

  localparam int STORE_AW = $clog2(STORE_DEPTH);
  localparam int ADDR_W   = 17;                      // request address plus offset
  localparam int CNT_W    = $clog2(MAX_READ_BITS + 1);
  localparam int NCNT_W   = 6;                       // elements in one result, up to 32

  localparam int BITS_PER_BYTE    = 8;
  localparam int COILS_PER_RESULT = 32;
  localparam int WORDS_PER_RESULT = 2;

  localparam int CFG_W   = 13;
  localparam int CFG_NUM = 6;
  localparam int CFG_IW  = 3;

  localparam logic [CFG_IW-1:0] CFG_COIL_FIRST  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_COIL_LIMIT  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_HOLD_FIRST  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_HOLD_LIMIT  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_INPUT_FIRST = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_INPUT_LIMIT = 3'd5;

  localparam logic [CFG_W-1:0] CFG_RESET [CFG_NUM] = '{
    13'd0, 13'd4096, 13'd0, 13'd4096, 13'd0, 13'd4096
  };

  localparam logic [7:0] FN_READ_COILS = 8'd1;
  localparam logic [7:0] FN_READ_HOLD  = 8'd3;
  localparam logic [7:0] FN_READ_INPUT = 8'd4;
  localparam logic [7:0] FN_WRITE_ONE  = 8'd6;
  localparam logic [7:0] FN_WRITE_MANY = 8'd16;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ILLEGAL_FN = 2'd1;
  localparam logic [1:0] ST_QUANTITY   = 2'd2;
  localparam logic [1:0] ST_ADDRESS    = 2'd3;

  localparam logic [6:0] WIDX_MAX = 7'd127;

  typedef struct packed {
    logic [7:0]  mode;
    logic [15:0] start_addr;
    logic [15:0] count;
    logic [7:0]  byte_count;
    logic [15:0] word_value;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  func_echo;
    logic [15:0] echo_addr;
    logic [15:0] echo_word;
    logic [31:0] payload;
    logic [2:0]  payload_bytes;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    RES_EXC,
    RES_WR_ONE,
    RES_WR_MANY,
    RES_READ
  } res_kind_t;

  typedef struct packed {
    logic      clear;
    logic      capture;
    logic      check;
    logic      mw_step;
    logic      sw_write;
    logic      rd_start;
    logic      rd_issue;
    logic      emit;
    res_kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic busy;
    logic last_word;
    logic status_ok;
    logic is_read;
    logic is_wr_one;
    logic res_end;
    logic rd_done;
    logic out_free;
  } sts_t;

  // True when the window [addr, addr+quan) leaves [first, limit).
  function automatic logic window_fault(input logic [15:0] addr, input logic [15:0] quan,
                                        input logic [CFG_W-1:0] first,
                                        input logic [CFG_W-1:0] limit);
    logic [16:0] end_addr;
    end_addr = {1'b0, addr} + {1'b0, quan};
    return ({1'b0, addr} < {4'b0, first}) || (end_addr > {4'b0, limit});
  endfunction

endpackage

/* hw/rtl/modbus_register_server_unit.sv */
// Modbus register server: a 4096-word store served by a controller (mbrs_ctrl)
// and a datapath (mbrs_dp); depends on mbrs_pkg.
// Sequence: an accepted request passes the check and execute states before its result is loaded
// into the output register; a multiple-write data word without a result frees the input after them.
// Throughput: reads go one store access a cycle while a result is gathered, pausing while a result
// waits for the output register; a request is accepted while a result still waits.
// Reset: synchronous; the store is cleared by a pass over every word during which no item is taken.
module modbus_register_server_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mbrs_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mbrs_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [mbrs_pkg::CFG_IW-1:0] cfg_index,
  input  logic [mbrs_pkg::CFG_W-1:0]  cfg_wdata
);
  import mbrs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mbrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mbrs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* hw/rtl/mbrs_ctrl.sv */
// Controller state machine of the Modbus register server.
// Depends on mbrs_pkg; drives the datapath mbrs_dp through cmd_t and watches sts_t.
module mbrs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mbrs_pkg::sts_t sts,
  output mbrs_pkg::cmd_t cmd
);
  import mbrs_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_EXEC,
    S_READ,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t    state_r, state_nxt;
  res_kind_t kind_r, kind_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    cmd.kind  = kind_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.busy) begin
          // A data word of a multiple write; only the final one answers.
          cmd.mw_step = 1'b1;
          kind_nxt    = RES_WR_MANY;
          state_nxt   = sts.last_word ? S_EMIT : S_IDLE;
        end else if (sts.status_ok && sts.is_read) begin
          cmd.rd_start = 1'b1;
          kind_nxt     = RES_READ;
          state_nxt    = S_READ;
        end else if (sts.status_ok && sts.is_wr_one) begin
          cmd.sw_write = 1'b1;
          kind_nxt     = RES_WR_ONE;
          state_nxt    = S_EMIT;
        end else begin
          kind_nxt  = RES_EXC;
          state_nxt = S_EMIT;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        if (sts.res_end) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (kind_r == RES_READ && !sts.rd_done) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      kind_r  <= RES_EXC;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_accept_goes_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_CHECK))
    else $error("accepted item did not move to the check step");
  a_read_resumes: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && kind_r == RES_READ && !sts.rd_done) |=> (state_r == S_READ))
    else $error("read response stopped before its final result");
`endif

endmodule

/* hw/rtl/mbrs_dp.sv */
// Datapath of the Modbus register server: register store, configuration,
// request checks, write framing, read sequencing and the output register. Depends on mbrs_pkg.
module mbrs_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mbrs_pkg::cmd_t            cmd,
  output mbrs_pkg::sts_t            sts,
  input  mbrs_pkg::in_item_t        in_data,
  input  logic                      cfg_we,
  input  logic [mbrs_pkg::CFG_IW-1:0] cfg_index,
  input  logic [mbrs_pkg::CFG_W-1:0]  cfg_wdata,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mbrs_pkg::out_item_t       out_data
);
  import mbrs_pkg::*;

  logic [15:0]       mem [STORE_DEPTH];
  logic [15:0]       mem_q_r;
  logic              mem_we;
  logic [STORE_AW-1:0] mem_wa;
  logic [15:0]       mem_wd;

  logic [CFG_W-1:0]  cfg_r [CFG_NUM];
  logic [STORE_AW-1:0] clr_cnt_r;

  in_item_t          req_r;
  logic [1:0]        status_r;
  logic [1:0]        status_nxt;
  logic [1:0]        hdr_fault;

  logic              wbusy_r;
  logic [6:0]        widx_r;
  logic [15:0]       wbase_r;
  logic [6:0]        wquan_r;
  logic [1:0]        wfault_r;
  logic [ADDR_W-1:0] mw_addr;
  logic [ADDR_W-1:0] sw_addr;

  logic [CNT_W-1:0]  g_r;
  logic [CNT_W-1:0]  rem_r;
  logic [NCNT_W-1:0] ncnt_r;
  logic              coil_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_in;
  logic              pend_r;
  logic [4:0]        pend_j_r;
  logic              pend_in_r;
  logic [31:0]       acc_r;
  logic [NCNT_W-1:0] res_top;
  logic [6:0]        coil_bits;

  logic              out_valid_r;
  out_item_t         out_data_r;
  out_item_t         res;

  // Request checks: quantity first, then the address window; a single write checks only its address.
  always_comb begin
    case (req_r.mode)
      FN_READ_COILS: begin
        if (req_r.count == 16'd0 || req_r.count > 16'(MAX_READ_BITS)) begin
          status_nxt = ST_QUANTITY;
        end else if (window_fault(req_r.start_addr, req_r.count,
                                  cfg_r[CFG_COIL_FIRST], cfg_r[CFG_COIL_LIMIT])) begin
          status_nxt = ST_ADDRESS;
        end else begin
          status_nxt = ST_OK;
        end
      end
      FN_READ_HOLD, FN_READ_INPUT: begin
        if (req_r.count == 16'd0 || req_r.count > 16'(MAX_READ_REGS)) begin
          status_nxt = ST_QUANTITY;
        end else if (req_r.mode == FN_READ_HOLD) begin
          status_nxt = window_fault(req_r.start_addr, req_r.count,
                                    cfg_r[CFG_HOLD_FIRST], cfg_r[CFG_HOLD_LIMIT])
                       ? ST_ADDRESS : ST_OK;
        end else begin
          status_nxt = window_fault(req_r.start_addr, req_r.count,
                                    cfg_r[CFG_INPUT_FIRST], cfg_r[CFG_INPUT_LIMIT])
                       ? ST_ADDRESS : ST_OK;
        end
      end
      FN_WRITE_ONE: begin
        if ({1'b0, req_r.start_addr} < {4'b0, cfg_r[CFG_INPUT_FIRST]} ||
            {1'b0, req_r.start_addr} >= {4'b0, cfg_r[CFG_INPUT_LIMIT]}) begin
          status_nxt = ST_ADDRESS;
        end else begin
          status_nxt = ST_OK;
        end
      end
      default: begin
        status_nxt = ST_ILLEGAL_FN;
      end
    endcase

    if (req_r.count == 16'd0 || req_r.count > 16'(MAX_WRITE_REGS) ||
        {9'd0, req_r.byte_count} != {req_r.count, 1'b0}) begin
      hdr_fault = ST_QUANTITY;
    end else if (window_fault(req_r.start_addr, req_r.count,
                              cfg_r[CFG_INPUT_FIRST], cfg_r[CFG_INPUT_LIMIT])) begin
      hdr_fault = ST_ADDRESS;
    end else begin
      hdr_fault = ST_OK;
    end
  end

  assign mw_addr = {1'b0, wbase_r} + ADDR_W'(widx_r);
  assign sw_addr = {1'b0, req_r.start_addr};
  assign rd_addr = {1'b0, req_r.start_addr} + ADDR_W'(g_r);
  assign rd_in   = (rd_addr < ADDR_W'(STORE_DEPTH));

  // Single write port: clearing pass, multiple write word or single write.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_cnt_r;
    mem_wd = 16'd0;
    if (cmd.clear) begin
      mem_we = 1'b1;
    end else if (cmd.mw_step) begin
      mem_wa = mw_addr[STORE_AW-1:0];
      mem_wd = req_r.word_value;
      mem_we = (wfault_r == ST_OK) && (widx_r < wquan_r) &&
               (mw_addr < ADDR_W'(STORE_DEPTH));
    end else if (cmd.sw_write) begin
      mem_wa = sw_addr[STORE_AW-1:0];
      mem_wd = req_r.word_value;
      mem_we = (sw_addr < ADDR_W'(STORE_DEPTH));
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.rd_issue && rd_in) begin
      mem_q_r <= mem[rd_addr[STORE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CFG_NUM; i++) begin
        cfg_r[i] <= CFG_RESET[i];
      end
      clr_cnt_r <= '0;
    end else begin
      if (cfg_we && (cfg_index < CFG_IW'(CFG_NUM))) begin
        cfg_r[cfg_index] <= cfg_wdata;
      end
      if (cmd.clear) begin
        clr_cnt_r <= clr_cnt_r + STORE_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.check) begin
      status_r <= status_nxt;
    end
  end

  // Multiple write framing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wbusy_r  <= 1'b0;
      widx_r   <= '0;
      wbase_r  <= '0;
      wquan_r  <= '0;
      wfault_r <= ST_OK;
    end else if (cmd.check && !wbusy_r && req_r.mode == FN_WRITE_MANY) begin
      wbusy_r  <= 1'b1;
      widx_r   <= '0;
      wfault_r <= hdr_fault;
      wbase_r  <= (hdr_fault == ST_OK) ? req_r.start_addr : 16'd0;
      wquan_r  <= (hdr_fault == ST_OK) ? req_r.count[6:0] : 7'd0;
    end else if (cmd.mw_step) begin
      if (widx_r != WIDX_MAX) begin
        widx_r <= widx_r + 7'd1;
      end
      if (req_r.last_word) begin
        wbusy_r <= 1'b0;
      end
    end
  end

  // Read sequencing: one store read a cycle while in the read state, collected in the cycle after.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_r    <= '0;
      rem_r  <= '0;
      ncnt_r <= '0;
      coil_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.rd_issue;
      if (cmd.rd_start) begin
        g_r    <= '0;
        rem_r  <= req_r.count[CNT_W-1:0];
        ncnt_r <= '0;
        coil_r <= (req_r.mode == FN_READ_COILS);
      end else if (cmd.rd_issue) begin
        g_r    <= g_r + CNT_W'(1);
        rem_r  <= rem_r - CNT_W'(1);
        ncnt_r <= ncnt_r + NCNT_W'(1);
      end else if (cmd.emit) begin
        ncnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      pend_j_r  <= ncnt_r[4:0];
      pend_in_r <= rd_in;
    end
    if (cmd.rd_start || cmd.emit) begin
      acc_r <= '0;
    end else if (pend_r && pend_in_r) begin
      if (coil_r) begin
        acc_r[pend_j_r] <= |mem_q_r;
      end else if (!pend_j_r[0]) begin
        acc_r[31:16] <= mem_q_r;
      end else begin
        acc_r[15:0] <= mem_q_r;
      end
    end
  end

  assign res_top   = coil_r ? NCNT_W'(COILS_PER_RESULT - 1) : NCNT_W'(WORDS_PER_RESULT - 1);
  assign coil_bits = 7'(ncnt_r) + 7'(BITS_PER_BYTE - 1);

  always_comb begin
    res      = '0;
    res.last = 1'b1;
    case (cmd.kind)
      RES_EXC: begin
        res.status    = status_r;
        res.func_echo = req_r.mode;
      end
      RES_WR_ONE: begin
        res.func_echo = FN_WRITE_ONE;
        res.echo_addr = req_r.start_addr;
        res.echo_word = req_r.word_value;
      end
      RES_WR_MANY: begin
        res.func_echo = FN_WRITE_MANY;
        if (wfault_r != ST_OK) begin
          res.status = wfault_r;
        end else begin
          res.echo_addr = wbase_r;
          res.echo_word = {9'd0, wquan_r};
        end
      end
      RES_READ: begin
        res.func_echo = req_r.mode;
        res.payload   = acc_r;
        res.last      = (rem_r == '0);
        if (coil_r) begin
          res.payload_bytes = 3'(coil_bits / BITS_PER_BYTE);
        end else begin
          res.payload_bytes = {ncnt_r[1:0], 1'b0};
        end
      end
      default: begin
        res.status = ST_ILLEGAL_FN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.clear_done = (clr_cnt_r == STORE_AW'(STORE_DEPTH - 1));
  assign sts.busy       = wbusy_r;
  assign sts.last_word  = req_r.last_word;
  assign sts.status_ok  = (status_r == ST_OK);
  assign sts.is_read    = (req_r.mode == FN_READ_COILS) || (req_r.mode == FN_READ_HOLD) ||
                          (req_r.mode == FN_READ_INPUT);
  assign sts.is_wr_one  = (req_r.mode == FN_WRITE_ONE);
  assign sts.res_end    = (ncnt_r == res_top) || (rem_r == CNT_W'(1));
  assign sts.rd_done    = (rem_r == '0);
  assign sts.out_free   = !out_valid_r || out_ready;

`ifndef ASSERT_OFF
  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result loaded over one not yet taken");
  a_issue_within_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> (rem_r != '0))
    else $error("store read issued beyond the requested quantity");
`endif

endmodule
